>>> hdl/cevq_pkg.sv
// Shared types and constants for the coalescing event queue.
// Used by cevq_ctrl, cevq_dp and coalescing_event_queue_top.
package cevq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int ADDR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int FILL_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [7:0]  FLUSH_DELAY_RESET  = 8'd30;
  localparam logic [2:0]  HANDLER_MASK_RESET = 3'b111;
  localparam logic [15:0] COUNT_MAX          = 16'hFFFF;

  // configuration register indexes
  localparam logic REG_FLUSH_DELAY  = 1'b0;
  localparam logic REG_HANDLER_MASK = 1'b1;

  // input function codes
  localparam logic FUNC_QUEUE = 1'b0;
  localparam logic FUNC_DRAIN = 1'b1;

  // event kinds
  localparam logic [1:0] KIND_AUTOMATION = 2'd0;
  localparam logic [1:0] KIND_FOCUS      = 2'd1;
  localparam logic [1:0] KIND_PROPERTY   = 2'd2;

  // result types
  localparam logic [1:0] RES_STATUS      = 2'd0;
  localparam logic [1:0] RES_EVENT       = 2'd1;
  localparam logic [1:0] RES_EMPTY_DRAIN = 2'd2;

  // status codes
  localparam logic [1:0] ST_ACCEPTED  = 2'd0;
  localparam logic [1:0] ST_NO_HANDLER = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;

  // output register source select
  localparam logic [1:0] OSEL_STATUS = 2'd0;
  localparam logic [1:0] OSEL_ENTRY  = 2'd1;
  localparam logic [1:0] OSEL_EMPTY  = 2'd2;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] element;
    logic [31:0] code;
    logic [31:0] value;
    logic [15:0] count;
  } entry_t;

  // controller -> datapath
  typedef struct packed {
    logic       latch;      // capture the input beat
    logic       idx_clr;
    logic       idx_inc;
    logic       rd_ahead;   // read at idx + 1 instead of idx
    logic       shift_we;   // write read data back at idx
    logic       tail_we;    // write the new entry at the tail
    logic       found_set;  // key matched at idx, save merged count
    logic       fill_clr;
    logic       st_we;
    logic [1:0] st_val;
    logic       out_load;
    logic [1:0] osel;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic drain;
    logic fill_zero;
    logic full;
    logic handler_ok;
    logic focus;
    logic match;
    logic idx_last;   // idx is the final occupied entry
    logic idx2_last;  // idx + 1 is the final occupied entry
    logic out_free;
  } sts_t;

endpackage

>>> hdl/cevq_ctrl.sv
// Sequencer for the coalescing event queue: search, compaction and drain.
// Depends on cevq_pkg; drives the command struct of cevq_dp.
module cevq_ctrl
  import cevq_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  sts_t sts,
  output cmd_t cmd
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_DEC  = 4'd1;
  localparam logic [3:0] S_SRD  = 4'd2;
  localparam logic [3:0] S_SCMP = 4'd3;
  localparam logic [3:0] S_MRD  = 4'd4;
  localparam logic [3:0] S_MWR  = 4'd5;
  localparam logic [3:0] S_TAIL = 4'd6;
  localparam logic [3:0] S_RES  = 4'd7;
  localparam logic [3:0] S_DRD  = 4'd8;
  localparam logic [3:0] S_DOUT = 4'd9;

  logic [3:0] state, state_next;
  logic [1:0] osel_res, osel_res_next;

  assign in_stall = (state != S_IDLE);

  always_comb begin
    state_next    = state;
    osel_res_next = osel_res;
    cmd           = '0;
    cmd.osel      = osel_res;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch  = 1'b1;
          state_next = S_DEC;
        end
      end
      S_DEC: begin
        cmd.idx_clr = 1'b1;
        if (sts.drain) begin
          if (sts.fill_zero) begin
            osel_res_next = OSEL_EMPTY;
            state_next    = S_RES;
          end else begin
            state_next = S_DRD;
          end
        end else if (!sts.handler_ok) begin
          cmd.st_we     = 1'b1;
          cmd.st_val    = ST_NO_HANDLER;
          osel_res_next = OSEL_STATUS;
          state_next    = S_RES;
        end else if (sts.focus || sts.fill_zero) begin
          // nothing to search: focus never merges
          if (sts.full) begin
            cmd.st_we     = 1'b1;
            cmd.st_val    = ST_FULL;
            osel_res_next = OSEL_STATUS;
            state_next    = S_RES;
          end else begin
            state_next = S_TAIL;
          end
        end else begin
          state_next = S_SRD;
        end
      end
      S_SRD: begin
        state_next = S_SCMP;
      end
      S_SCMP: begin
        if (sts.match) begin
          cmd.found_set = 1'b1;
          state_next    = sts.idx_last ? S_TAIL : S_MRD;
        end else if (sts.idx_last) begin
          if (sts.full) begin
            cmd.st_we     = 1'b1;
            cmd.st_val    = ST_FULL;
            osel_res_next = OSEL_STATUS;
            state_next    = S_RES;
          end else begin
            state_next = S_TAIL;
          end
        end else begin
          cmd.idx_inc = 1'b1;
          state_next  = S_SRD;
        end
      end
      S_MRD: begin
        cmd.rd_ahead = 1'b1;
        state_next   = S_MWR;
      end
      S_MWR: begin
        // close the gap left by the merged entry
        cmd.shift_we = 1'b1;
        cmd.idx_inc  = 1'b1;
        state_next   = sts.idx2_last ? S_TAIL : S_MRD;
      end
      S_TAIL: begin
        cmd.tail_we   = 1'b1;
        cmd.st_we     = 1'b1;
        cmd.st_val    = ST_ACCEPTED;
        osel_res_next = OSEL_STATUS;
        state_next    = S_RES;
      end
      S_RES: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      S_DRD: begin
        state_next = S_DOUT;
      end
      S_DOUT: begin
        cmd.osel = OSEL_ENTRY;
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          if (sts.idx_last) begin
            cmd.fill_clr = 1'b1;
            state_next   = S_IDLE;
          end else begin
            cmd.idx_inc = 1'b1;
            state_next  = S_DRD;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      osel_res <= OSEL_STATUS;
    end else begin
      state    <= state_next;
      osel_res <= osel_res_next;
    end
  end

endmodule

>>> hdl/cevq_dp.sv
// Datapath of the coalescing event queue: entry memory, fill count, index,
// configuration registers and the output register. Depends on cevq_pkg.
module cevq_dp
  import cevq_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  cmd_t        cmd,
  output sts_t        sts,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_data,
  input  logic        func,
  input  logic [1:0]  event_kind,
  input  logic [31:0] element_id,
  input  logic [31:0] event_code,
  input  logic [31:0] prop_value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  result_type,
  output logic [1:0]  status,
  output logic        flush_request,
  output logic [7:0]  flush_delay,
  output logic [1:0]  out_kind,
  output logic [31:0] out_element,
  output logic [31:0] out_code,
  output logic [31:0] out_value,
  output logic [15:0] coalesce_count,
  output logic        last
);

  entry_t mem [QUEUE_DEPTH];
  entry_t rd_data;
  logic [ADDR_W-1:0] rd_addr, wr_addr;
  entry_t wr_data;
  logic wr_en;

  logic [7:0]  delay_reg;
  logic [2:0]  mask_reg;
  logic [3:0]  mask_ext;

  logic        func_q;
  logic [1:0]  kind_q;
  logic [31:0] elem_q, code_q, val_q;
  logic [15:0] cnt_q;
  logic        found_q;
  logic [1:0]  res_status;
  logic        res_flush;

  logic [FILL_W-1:0] fill;
  logic [ADDR_W-1:0] idx;
  logic [FILL_W-1:0] idx_ext;
  logic [15:0] merged_cnt;
  logic        out_free;

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      delay_reg <= FLUSH_DELAY_RESET;
      mask_reg  <= HANDLER_MASK_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FLUSH_DELAY:  delay_reg <= cfg_data;
        REG_HANDLER_MASK: mask_reg  <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  // input beat, with the fields a kind does not use forced to zero
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      func_q <= func;
      kind_q <= event_kind;
      elem_q <= element_id;
      code_q <= (event_kind == KIND_FOCUS) ? 32'd0 : event_code;
      val_q  <= (event_kind == KIND_PROPERTY) ? prop_value : 32'd0;
    end
  end

  assign merged_cnt = (rd_data.count == COUNT_MAX) ? COUNT_MAX : rd_data.count + 16'd1;

  always_ff @(posedge clk) begin
    if (rst) begin
      found_q <= 1'b0;
    end else if (cmd.latch) begin
      found_q <= 1'b0;
    end else if (cmd.found_set) begin
      found_q <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      cnt_q <= 16'd1;
    end else if (cmd.found_set) begin
      cnt_q <= merged_cnt;
    end
  end

  // index and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (cmd.idx_clr) begin
      idx <= '0;
    end else if (cmd.idx_inc) begin
      idx <= idx + ADDR_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
    end else if (cmd.fill_clr) begin
      fill <= '0;
    end else if (cmd.tail_we && !found_q) begin
      fill <= fill + FILL_W'(1);
    end
  end

  // entry memory
  assign rd_addr = cmd.rd_ahead ? idx + ADDR_W'(1) : idx;
  assign wr_en   = cmd.shift_we || cmd.tail_we;
  assign wr_addr = cmd.tail_we ? (found_q ? ADDR_W'(fill - FILL_W'(1)) : ADDR_W'(fill)) : idx;

  always_comb begin
    if (cmd.tail_we) begin
      wr_data.kind    = kind_q;
      wr_data.element = elem_q;
      wr_data.code    = code_q;
      wr_data.value   = val_q;
      wr_data.count   = cnt_q;
    end else begin
      wr_data = rd_data;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

  // result of a queue request; flush fields follow the fill before the write
  always_ff @(posedge clk) begin
    if (cmd.st_we) begin
      res_status <= cmd.st_val;
      res_flush  <= (cmd.st_val == ST_ACCEPTED) && ((kind_q == KIND_FOCUS) || (fill == '0));
    end
  end

  assign idx_ext = FILL_W'(idx);

  // the unused fourth kind finds a zero bit and counts as having no handler
  assign mask_ext = {1'b0, mask_reg};

  always_comb begin
    sts.drain      = (func_q == FUNC_DRAIN);
    sts.fill_zero  = (fill == '0);
    sts.full       = (fill == FILL_W'(QUEUE_DEPTH));
    sts.handler_ok = mask_ext[kind_q];
    sts.focus      = (kind_q == KIND_FOCUS);
    sts.match      = (rd_data.kind == kind_q) && (rd_data.element == elem_q) &&
                     (rd_data.code == code_q);
    sts.idx_last   = (idx_ext + FILL_W'(1) == fill);
    sts.idx2_last  = (idx_ext + FILL_W'(2) == fill);
    sts.out_free   = out_free;
  end

  // output register
  assign out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      result_type    <= RES_STATUS;
      status         <= ST_ACCEPTED;
      flush_request  <= 1'b0;
      flush_delay    <= 8'd0;
      out_kind       <= 2'd0;
      out_element    <= 32'd0;
      out_code       <= 32'd0;
      out_value      <= 32'd0;
      coalesce_count <= 16'd0;
      last           <= 1'b1;
      case (cmd.osel)
        OSEL_STATUS: begin
          status        <= res_status;
          flush_request <= res_flush;
          flush_delay   <= (res_flush && (kind_q != KIND_FOCUS)) ? delay_reg : 8'd0;
        end
        OSEL_ENTRY: begin
          result_type    <= RES_EVENT;
          out_kind       <= rd_data.kind;
          out_element    <= rd_data.element;
          out_code       <= rd_data.code;
          out_value      <= rd_data.value;
          coalesce_count <= rd_data.count;
          last           <= sts.idx_last;
        end
        OSEL_EMPTY: begin
          result_type <= RES_EMPTY_DRAIN;
        end
        default: ;
      endcase
    end
  end

endmodule

>>> hdl/coalescing_event_queue_top.sv
// Top level of the coalescing event queue; joins cevq_ctrl and cevq_dp.
// Depends on cevq_pkg.
//
// The block takes one beat at a time. Entries sit in a single-port-read
// memory, so each step reads one entry and acts on it next cycle. A queue
// request searches the entries up to the fill level (none for focus) and,
// after a merge, moves the entries behind the merged one up by one place
// before its status result is loaded; the entries searched and the entries
// moved together never exceed the fill level. A drain reads the entries
// out one at a time and waits while the output is stalled.
// A new beat is taken as soon as the result register is loaded, while that
// result still waits on the output side.
// Configuration writes are always taken (cfg_ready is high).
module coalescing_event_queue_top
  import cevq_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        func,
  input  logic [1:0]  event_kind,
  input  logic [31:0] element_id,
  input  logic [31:0] event_code,
  input  logic [31:0] prop_value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  result_type,
  output logic [1:0]  status,
  output logic        flush_request,
  output logic [7:0]  flush_delay,
  output logic [1:0]  out_kind,
  output logic [31:0] out_element,
  output logic [31:0] out_code,
  output logic [31:0] out_value,
  output logic [15:0] coalesce_count,
  output logic        last
);

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready = 1'b1;

  cevq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  cevq_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .sts            (sts),
    .cfg_we         (cfg_valid && cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .func           (func),
    .event_kind     (event_kind),
    .element_id     (element_id),
    .event_code     (event_code),
    .prop_value     (prop_value),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .result_type    (result_type),
    .status         (status),
    .flush_request  (flush_request),
    .flush_delay    (flush_delay),
    .out_kind       (out_kind),
    .out_element    (out_element),
    .out_code       (out_code),
    .out_value      (out_value),
    .coalesce_count (coalesce_count),
    .last           (last)
  );

endmodule
